// ===== design/sahe_pkg.sv =====
// Package for the sensor alert holdoff engine: widths, alert kind codes,
// register indexes and the structs passed between the engine modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sahe_pkg;

    // Alert kinds, one cooldown entry each
    localparam int ALERT_KINDS = 5;
    localparam int KIND_W      = $clog2(ALERT_KINDS);
    localparam int TIME_W      = 32;
    localparam int TENTHS_W    = 10;
    localparam int RUN_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OCC_W       = 2;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [OCC_W-1:0]     occ_t;

    localparam kind_t KIND_STRESS       = kind_t'(0);
    localparam kind_t KIND_GEOFENCE     = kind_t'(1);
    localparam kind_t KIND_LOW_SPO2     = kind_t'(2);
    localparam kind_t KIND_SENSOR_FAIL  = kind_t'(3);
    localparam kind_t KIND_LOW_BATTERY  = kind_t'(4);
    localparam kind_t KIND_FIRST        = KIND_STRESS;
    localparam kind_t KIND_LAST         = KIND_LOW_BATTERY;

    localparam cfg_idx_t REG_COOLDOWN     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_ACTIVE_WIN   = cfg_idx_t'(1);
    localparam cfg_idx_t REG_SPO2_LOW     = cfg_idx_t'(2);
    localparam cfg_idx_t REG_BATTERY_LOW  = cfg_idx_t'(3);
    localparam cfg_idx_t REG_SPO2_RUNS    = cfg_idx_t'(4);

    localparam logic [TIME_W-1:0]   COOLDOWN_RST    = TIME_W'(300000);
    localparam logic [TIME_W-1:0]   ACTIVE_WIN_RST  = TIME_W'(60000);
    localparam logic [TENTHS_W-1:0] SPO2_LOW_RST    = TENTHS_W'(900);
    localparam logic [TENTHS_W-1:0] BATTERY_LOW_RST = TENTHS_W'(150);
    localparam logic [RUN_W-1:0]    SPO2_RUNS_RST   = RUN_W'(3);
    localparam logic [RUN_W-1:0]    RUN_MAX         = '1;

    // Results held in flight plus waiting at the output
    localparam occ_t OCC_MAX = occ_t'(2);

    // One cooldown lookup: the kind being judged and what it needs
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [TIME_W-1:0] now;
        logic              cal;
        logic              cond;    // trigger, or raw low-SpO2 reading for that kind
    } eval_req_t;

    typedef struct packed {
        logic [ALERT_KINDS-1:0] fired;
        logic                   vibrate;
        logic                   active;
    } alert_result_t;

endpackage

`default_nettype wire

// ===== design/sahe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sahe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/sahe_eval.sv =====
// Cooldown judge: takes the read-back last-alert time of one kind, decides
// whether it fires, writes the time back and keeps run and window state.
// Depends on sahe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sahe_eval (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sahe_pkg::eval_req_t                req,
    input  wire logic [sahe_pkg::TIME_W-1:0]        rd_data,
    input  wire logic [sahe_pkg::TIME_W-1:0]        cooldown,
    input  wire logic [sahe_pkg::TIME_W-1:0]        active_win,
    input  wire logic [sahe_pkg::RUN_W-1:0]         spo2_runs,
    output logic                                    wr_en,
    output sahe_pkg::kind_t                         wr_addr,
    output logic [sahe_pkg::TIME_W-1:0]             wr_data,
    output logic                                    res_valid,
    output sahe_pkg::alert_result_t                 res
);

    // Entries never written read as zero
    logic [sahe_pkg::ALERT_KINDS-1:0] ent_valid_reg, ent_valid_next;
    logic                             recent_flag_reg, recent_flag_next;
    logic [sahe_pkg::TIME_W-1:0]      recent_time_reg, recent_time_next;
    logic [sahe_pkg::RUN_W-1:0]       run_reg, run_next;
    logic [sahe_pkg::ALERT_KINDS-1:0] fired_acc_reg, fired_acc_next;

    logic [sahe_pkg::TIME_W-1:0]      last_time;
    logic [sahe_pkg::TIME_W-1:0]      elapsed;
    logic [sahe_pkg::TIME_W-1:0]      win_elapsed;
    logic [sahe_pkg::RUN_W-1:0]       run_upd;
    logic [sahe_pkg::RUN_W-1:0]       need;
    logic                             trig;
    logic                             fire;
    logic                             live;

    always_comb
    begin
        live      = req.valid && req.cal;
        last_time = ent_valid_reg[req.kind] ? rd_data : '0;
        elapsed   = req.now - last_time;

        if (!req.cond)
        begin
            run_upd = '0;
        end
        else if (run_reg == sahe_pkg::RUN_MAX)
        begin
            run_upd = run_reg;
        end
        else
        begin
            run_upd = run_reg + sahe_pkg::RUN_W'(1);
        end
        need = (spo2_runs == '0) ? sahe_pkg::RUN_W'(1) : spo2_runs;

        trig = (req.kind == sahe_pkg::KIND_LOW_SPO2) ? (run_upd >= need) : req.cond;
        fire = live && trig && (elapsed >= cooldown);

        wr_en   = fire;
        wr_addr = req.kind;
        wr_data = req.now;

        ent_valid_next   = ent_valid_reg;
        recent_flag_next = recent_flag_reg;
        recent_time_next = recent_time_reg;
        run_next         = run_reg;
        if (fire)
        begin
            ent_valid_next[req.kind] = 1'b1;
        end
        if (fire && (req.kind == sahe_pkg::KIND_STRESS ||
                     req.kind == sahe_pkg::KIND_GEOFENCE))
        begin
            recent_flag_next = 1'b1;
            recent_time_next = req.now;
        end
        if (live && req.kind == sahe_pkg::KIND_LOW_SPO2)
        begin
            run_next = fire ? '0 : run_upd;
        end

        fired_acc_next = fired_acc_reg;
        if (req.valid)
        begin
            fired_acc_next[req.kind] = fire;
        end

        // Window judged after this item's updates; the last kind touches none
        win_elapsed = req.now - recent_time_reg;

        res_valid   = req.valid && (req.kind == sahe_pkg::KIND_LAST);
        res.fired   = fired_acc_next;
        res.vibrate = fired_acc_next[sahe_pkg::KIND_STRESS] |
                      fired_acc_next[sahe_pkg::KIND_GEOFENCE];
        res.active  = recent_flag_reg && (win_elapsed < active_win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg   <= '0;
            recent_flag_reg <= 1'b0;
            recent_time_reg <= '0;
            run_reg         <= '0;
        end
        else
        begin
            ent_valid_reg   <= ent_valid_next;
            recent_flag_reg <= recent_flag_next;
            recent_time_reg <= recent_time_next;
            run_reg         <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_acc_reg <= fired_acc_next;
    end

endmodule

`default_nettype wire

// ===== design/sahe_out_queue.sv =====
// Two-entry result queue in front of the output channel.
// Depends on sahe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sahe_out_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire sahe_pkg::alert_result_t push_data,
    input  wire logic                    pop,
    output logic                         q_valid,
    output sahe_pkg::alert_result_t      q_data
);

    logic                    head_valid_reg, head_valid_next;
    logic                    hold_valid_reg, hold_valid_next;
    sahe_pkg::alert_result_t head_reg, head_next;
    sahe_pkg::alert_result_t hold_reg, hold_next;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        hold_valid_next = hold_valid_reg;
        head_next       = head_reg;
        hold_next       = hold_reg;

        if (pop)
        begin
            // advance the second entry, or empty the head
            head_valid_next = hold_valid_reg;
            head_next       = hold_reg;
            hold_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_valid_next = 1'b1;
                head_next       = push_data;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_next       = push_data;
            end
        end

        q_valid = head_valid_reg;
        q_data  = head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

// ===== design/sensor_alert_holdoff_engine.sv =====
// Top level of the sensor alert holdoff engine: config registers, kind
// sequencer, cooldown-time RAM, evaluator and output queue.
// Depends on sahe_pkg, sahe_ram, sahe_eval and sahe_out_queue.
//
// Usage:
//   One transfer on the input channel (in_valid high, in_stall low) carries one
//   sensor evaluation. One transfer on the output channel (out_valid high,
//   out_stall low) returns its seven alert bits, in order, one per item.
//   The five per-kind last-alert times live in a 5-entry RAM. The sequencer
//   walks the kinds one per cycle: read the entry, judge the cooldown in the
//   next cycle and write the new time back. An item holds the RAM port until
//   its last kind is issued; the next item is taken in the cycle its
//   predecessor issues its last kind, if a result slot is free. An entry is
//   always written before the next item reads it, so no forwarding is needed.
//   out_valid rises once the evaluator has pushed the result after the last
//   kind and the output queue has registered it.
//   When the receiver stalls, up to two results wait in the output queue; once
//   two items are outstanding (in flight or waiting), in_stall holds further
//   input until a result transfers.
//   Reset clears the config registers to their defaults, the last-alert times
//   (through per-entry valid bits), the SpO2 run and the alert window.
//   Config writes (cfg_we, cfg_index, cfg_data) are expected only while idle.
`timescale 1ns / 1ps
`default_nettype none

module sensor_alert_holdoff_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [sahe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sahe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [sahe_pkg::TIME_W-1:0]         now_ms,
    input  wire logic                                calibrated,
    input  wire logic                                stress_state,
    input  wire logic                                gps_fixed,
    input  wire logic                                outside_fence,
    input  wire logic                                spo2_error,
    input  wire logic                                any_sensor_error,
    input  wire logic [sahe_pkg::TENTHS_W-1:0]       spo2_tenths,
    input  wire logic [sahe_pkg::TENTHS_W-1:0]       battery_tenths,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     stress_fired,
    output logic                                     geofence_fired,
    output logic                                     low_spo2_fired,
    output logic                                     sensor_fail_fired,
    output logic                                     low_battery_fired,
    output logic                                     vibrate_request,
    output logic                                     alert_active
);

    // Configuration registers
    logic [sahe_pkg::TIME_W-1:0]   cooldown_reg, cooldown_next;
    logic [sahe_pkg::TIME_W-1:0]   active_win_reg, active_win_next;
    logic [sahe_pkg::TENTHS_W-1:0] spo2_low_reg, spo2_low_next;
    logic [sahe_pkg::TENTHS_W-1:0] battery_low_reg, battery_low_next;
    logic [sahe_pkg::RUN_W-1:0]    spo2_runs_reg, spo2_runs_next;

    // Kind sequencer and the item being walked
    logic                             busy_reg, busy_next;
    sahe_pkg::kind_t                  kind_reg, kind_next;
    logic [sahe_pkg::TIME_W-1:0]      item_now_reg, item_now_next;
    logic                             item_cal_reg, item_cal_next;
    logic [sahe_pkg::ALERT_KINDS-1:0] item_cond_reg, item_cond_next;

    // Lookup in flight to the evaluator, aligned with RAM read data
    sahe_pkg::eval_req_t              req_reg, req_next;

    sahe_pkg::occ_t                   occ_reg, occ_next;

    logic                             in_xfer;
    logic                             pop;
    logic                             wr_en;
    sahe_pkg::kind_t                  wr_addr;
    logic [sahe_pkg::TIME_W-1:0]      wr_data;
    logic [sahe_pkg::TIME_W-1:0]      rd_data;
    logic                             res_valid;
    sahe_pkg::alert_result_t          res;
    logic                             q_valid;
    sahe_pkg::alert_result_t          q_data;

    // Config write decode
    always_comb
    begin
        cooldown_next    = cooldown_reg;
        active_win_next  = active_win_reg;
        spo2_low_next    = spo2_low_reg;
        battery_low_next = battery_low_reg;
        spo2_runs_next   = spo2_runs_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sahe_pkg::REG_COOLDOWN:    cooldown_next    = cfg_data;
                sahe_pkg::REG_ACTIVE_WIN:  active_win_next  = cfg_data;
                sahe_pkg::REG_SPO2_LOW:    spo2_low_next    = cfg_data[sahe_pkg::TENTHS_W-1:0];
                sahe_pkg::REG_BATTERY_LOW: battery_low_next = cfg_data[sahe_pkg::TENTHS_W-1:0];
                sahe_pkg::REG_SPO2_RUNS:   spo2_runs_next   = cfg_data[sahe_pkg::RUN_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Input side: take a new item when the RAM port frees up and a result
    // slot is guaranteed
    always_comb
    begin
        pop      = q_valid && !out_stall;
        in_stall = (busy_reg && (kind_reg != sahe_pkg::KIND_LAST)) ||
                   ((occ_reg == sahe_pkg::OCC_MAX) && !pop);
        in_xfer  = in_valid && !in_stall;

        occ_next = occ_reg;
        if (in_xfer && !pop)
        begin
            occ_next = occ_reg + sahe_pkg::occ_t'(1);
        end
        else if (!in_xfer && pop)
        begin
            occ_next = occ_reg - sahe_pkg::occ_t'(1);
        end
    end

    // Sequencer: issue one kind per cycle; capture triggers at transfer time
    always_comb
    begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        item_now_next  = item_now_reg;
        item_cal_next  = item_cal_reg;
        item_cond_next = item_cond_reg;

        if (in_xfer)
        begin
            busy_next     = 1'b1;
            kind_next     = sahe_pkg::KIND_FIRST;
            item_now_next = now_ms;
            item_cal_next = calibrated;
            item_cond_next[sahe_pkg::KIND_STRESS]      = stress_state;
            item_cond_next[sahe_pkg::KIND_GEOFENCE]    = gps_fixed && outside_fence;
            item_cond_next[sahe_pkg::KIND_LOW_SPO2]    = !spo2_error &&
                                                         (spo2_tenths < spo2_low_reg);
            item_cond_next[sahe_pkg::KIND_SENSOR_FAIL] = any_sensor_error;
            item_cond_next[sahe_pkg::KIND_LOW_BATTERY] = battery_tenths < battery_low_reg;
        end
        else if (busy_reg)
        begin
            if (kind_reg == sahe_pkg::KIND_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                kind_next = kind_reg + sahe_pkg::kind_t'(1);
            end
        end

        req_next.valid = busy_reg;
        req_next.kind  = kind_reg;
        req_next.now   = item_now_reg;
        req_next.cal   = item_cal_reg;
        req_next.cond  = item_cond_reg[kind_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg    <= sahe_pkg::COOLDOWN_RST;
            active_win_reg  <= sahe_pkg::ACTIVE_WIN_RST;
            spo2_low_reg    <= sahe_pkg::SPO2_LOW_RST;
            battery_low_reg <= sahe_pkg::BATTERY_LOW_RST;
            spo2_runs_reg   <= sahe_pkg::SPO2_RUNS_RST;
            busy_reg        <= 1'b0;
            kind_reg        <= sahe_pkg::KIND_FIRST;
            req_reg         <= '0;
            occ_reg         <= '0;
        end
        else
        begin
            cooldown_reg    <= cooldown_next;
            active_win_reg  <= active_win_next;
            spo2_low_reg    <= spo2_low_next;
            battery_low_reg <= battery_low_next;
            spo2_runs_reg   <= spo2_runs_next;
            busy_reg        <= busy_next;
            kind_reg        <= kind_next;
            req_reg         <= req_next;
            occ_reg         <= occ_next;
        end
    end

    // Item payload carries no reset
    always_ff @(posedge clk)
    begin
        item_now_reg  <= item_now_next;
        item_cal_reg  <= item_cal_next;
        item_cond_reg <= item_cond_next;
    end

    // Last-alert times, one entry per kind; read in issue, written in judge
    sahe_ram #(
        .WIDTH (sahe_pkg::TIME_W),
        .DEPTH (sahe_pkg::ALERT_KINDS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (kind_reg),
        .rd_data (rd_data)
    );

    sahe_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_reg),
        .rd_data    (rd_data),
        .cooldown   (cooldown_reg),
        .active_win (active_win_reg),
        .spo2_runs  (spo2_runs_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    sahe_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    assign out_valid         = q_valid;
    assign stress_fired      = q_data.fired[sahe_pkg::KIND_STRESS];
    assign geofence_fired    = q_data.fired[sahe_pkg::KIND_GEOFENCE];
    assign low_spo2_fired    = q_data.fired[sahe_pkg::KIND_LOW_SPO2];
    assign sensor_fail_fired = q_data.fired[sahe_pkg::KIND_SENSOR_FAIL];
    assign low_battery_fired = q_data.fired[sahe_pkg::KIND_LOW_BATTERY];
    assign vibrate_request   = q_data.vibrate;
    assign alert_active      = q_data.active;

    // Outstanding items never exceed the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= sahe_pkg::OCC_MAX)
        else $error("outstanding item count above queue depth");

    // A walk in progress is always counted as outstanding
    a_busy_counted: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (occ_reg != '0))
        else $error("sequencer busy with no outstanding item");

    // A shown result belongs to an outstanding item
    a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occ_reg != '0))
        else $error("result shown with no outstanding item");

    // A kind past the first is only reached from an active walk
    a_kind_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (kind_reg != sahe_pkg::KIND_FIRST)) |-> $past(busy_reg))
        else $error("kind sequencer advanced without a walk");

    // The result is pushed in the cycle after the last kind is issued
    a_push_align: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (kind_reg == sahe_pkg::KIND_LAST)) |=> res_valid)
        else $error("result not pushed after last kind");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for sensor_alert_holdoff_engine: sends sensor evaluations with random
// idle and output stall, predicts the seven alert bits of each transfer and checks them.
// Depends on sahe_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
    import sahe_pkg::*;

    // One sensor evaluation as it goes into the engine
    typedef struct packed {
        logic [TIME_W-1:0]   now;
        logic                cal;
        logic                stress;
        logic                fixed;
        logic                outside;
        logic                spo2_err;
        logic                any_err;
        logic [TENTHS_W-1:0] spo2;
        logic [TENTHS_W-1:0] batt;
    } reading_t;

    // The seven alert bits returned per evaluation
    typedef struct packed {
        logic stress;
        logic geo;
        logic spo2;
        logic fail;
        logic batt;
        logic vibrate;
        logic active;
    } alerts_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    cfg_idx_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [TIME_W-1:0]   now_ms;
    logic                calibrated;
    logic                stress_state;
    logic                gps_fixed;
    logic                outside_fence;
    logic                spo2_error;
    logic                any_sensor_error;
    logic [TENTHS_W-1:0] spo2_tenths;
    logic [TENTHS_W-1:0] battery_tenths;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                stress_fired;
    logic                geofence_fired;
    logic                low_spo2_fired;
    logic                sensor_fail_fired;
    logic                low_battery_fired;
    logic                vibrate_request;
    logic                alert_active;

    // Predictor copy of the registers and the holdoff state
    logic [TIME_W-1:0]   cd_ms;
    logic [TIME_W-1:0]   win_ms;
    logic [TENTHS_W-1:0] spo2_thr;
    logic [TENTHS_W-1:0] batt_thr;
    logic [RUN_W-1:0]    runs_need;
    logic [TIME_W-1:0]   last_fire [ALERT_KINDS];
    logic                recent_flag;
    logic [TIME_W-1:0]   recent_ms;
    logic [RUN_W-1:0]    spo2_run;

    alerts_t             alerts_q[$];     // predicted alerts, oldest first
    int                  errors = 0;
    bit                  calm = 1'b0;     // set: neither side idles
    logic [TIME_W-1:0]   clock_ms;        // running timestamp of the random phases

    sensor_alert_holdoff_engine dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .now_ms            (now_ms),
        .calibrated        (calibrated),
        .stress_state      (stress_state),
        .gps_fixed         (gps_fixed),
        .outside_fence     (outside_fence),
        .spo2_error        (spo2_error),
        .any_sensor_error  (any_sensor_error),
        .spo2_tenths       (spo2_tenths),
        .battery_tenths    (battery_tenths),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .stress_fired      (stress_fired),
        .geofence_fired    (geofence_fired),
        .low_spo2_fired    (low_spo2_fired),
        .sensor_fail_fired (sensor_fail_fired),
        .low_battery_fired (low_battery_fired),
        .vibrate_request   (vibrate_request),
        .alert_active      (alert_active)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void holdoff_reset();
        cd_ms       = COOLDOWN_RST;
        win_ms      = ACTIVE_WIN_RST;
        spo2_thr    = SPO2_LOW_RST;
        batt_thr    = BATTERY_LOW_RST;
        runs_need   = SPO2_RUNS_RST;
        for (int k = 0; k < ALERT_KINDS; k++)
            last_fire[k] = '0;
        recent_flag = 1'b0;
        recent_ms   = '0;
        spo2_run    = '0;
    endfunction

    // Fire a kind only once its cooldown has run out; stamp the new time on success.
    // The difference wraps modulo 2^32.
    function automatic logic claim_kind(input kind_t k, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since;
        since = now - last_fire[k];
        if (since < cd_ms)
            return 1'b0;
        last_fire[k] = now;
        return 1'b1;
    endfunction

    function automatic alerts_t judge_reading(input reading_t r);
        alerts_t           a;
        logic [RUN_W-1:0]  need;
        logic [TIME_W-1:0] since;
        a    = '0;
        need = (runs_need == '0) ? RUN_W'(1) : runs_need;
        // Uncalibrated readings fire nothing and leave the state alone
        if (r.cal)
        begin
            if (r.stress)
            begin
                if (claim_kind(KIND_STRESS, r.now))
                begin
                    a.stress    = 1'b1;
                    recent_flag = 1'b1;
                    recent_ms   = r.now;
                end
            end
            if (r.fixed && r.outside)
            begin
                if (claim_kind(KIND_GEOFENCE, r.now))
                begin
                    a.geo       = 1'b1;
                    recent_flag = 1'b1;
                    recent_ms   = r.now;
                end
            end
            // Advance the low SpO2 run first, saturating; any good reading drops it
            if (!r.spo2_err && r.spo2 < spo2_thr)
            begin
                if (spo2_run != RUN_MAX)
                    spo2_run = spo2_run + 1'b1;
            end
            else
                spo2_run = '0;
            if (spo2_run >= need)
            begin
                if (claim_kind(KIND_LOW_SPO2, r.now))
                begin
                    a.spo2   = 1'b1;
                    spo2_run = '0;
                end
            end
            if (r.any_err)
                a.fail = claim_kind(KIND_SENSOR_FAIL, r.now);
            if (r.batt < batt_thr)
                a.batt = claim_kind(KIND_LOW_BATTERY, r.now);
        end
        a.vibrate = a.stress | a.geo;
        // Judge the active window after this reading's updates
        since    = r.now - recent_ms;
        a.active = recent_flag && (since < win_ms);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic reading_t make_reading(
        input logic [TIME_W-1:0] now,
        input logic cal, stress, fixed, outside, spo2_err, any_err,
        input logic [TENTHS_W-1:0] spo2, batt);
        reading_t r;
        r = '{now, cal, stress, fixed, outside, spo2_err, any_err, spo2, batt};
        return r;
    endfunction

    // Mostly well-formed readings: calibrated, with low values clustered under the
    // current thresholds so that runs build up and alerts actually fire.
    function automatic reading_t random_reading(input logic [TIME_W-1:0] now);
        reading_t r;
        r.now      = now;
        r.cal      = ($urandom_range(99) < 90);
        r.stress   = ($urandom_range(99) < 30);
        r.fixed    = 1'($urandom_range(1));
        r.outside  = 1'($urandom_range(1));
        r.spo2_err = ($urandom_range(99) < 10);
        r.any_err  = ($urandom_range(99) < 15);
        if ($urandom_range(99) < 65 && spo2_thr != '0)
            r.spo2 = TENTHS_W'($urandom_range(0, (spo2_thr > 1000) ? 1000 : spo2_thr - 1));
        else
            r.spo2 = TENTHS_W'($urandom_range(0, 1000));
        if ($urandom_range(99) < 25 && batt_thr != '0)
            r.batt = TENTHS_W'($urandom_range(0, (batt_thr > 1000) ? 1000 : batt_thr - 1));
        else
            r.batt = TENTHS_W'($urandom_range(0, 1000));
        return r;
    endfunction

    // Drive one reading and hold it until the engine takes the transfer.
    // Idle cycles go in front; valid is never dropped and raised in one step.
    task automatic send_reading(input reading_t r);
        if (!calm)
        begin
            while ($urandom_range(99) < 25)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid         <= 1'b1;
        now_ms           <= r.now;
        calibrated       <= r.cal;
        stress_state     <= r.stress;
        gps_fixed        <= r.fixed;
        outside_fence    <= r.outside;
        spo2_error       <= r.spo2_err;
        any_sensor_error <= r.any_err;
        spo2_tenths      <= r.spo2;
        battery_tenths   <= r.batt;
        do
            @(posedge clk);
        while (in_stall);
        alerts_q.push_back(judge_reading(r));
    endtask

    // Drain: wait for every predicted result, then let the pipeline settle
    task automatic wait_idle();
        while (alerts_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write all five registers back to back, only once the engine is idle
    task automatic write_config(
        input logic [TIME_W-1:0] cd, win,
        input logic [TENTHS_W-1:0] spo2_low, batt_low,
        input logic [RUN_W-1:0] runs);
        cfg_idx_t              idx  [5];
        logic [CFG_DATA_W-1:0] data [5];
        idx[0] = REG_COOLDOWN;    data[0] = cd;
        idx[1] = REG_ACTIVE_WIN;  data[1] = win;
        idx[2] = REG_SPO2_LOW;    data[2] = CFG_DATA_W'(spo2_low);
        idx[3] = REG_BATTERY_LOW; data[3] = CFG_DATA_W'(batt_low);
        idx[4] = REG_SPO2_RUNS;   data[4] = CFG_DATA_W'(runs);
        in_valid <= 1'b0;
        wait_idle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        cd_ms     = cd;
        win_ms    = win;
        spo2_thr  = spo2_low;
        batt_thr  = batt_low;
        runs_need = runs;
    endtask

    // Random phase: advance time by up to max_step per reading; wild mixes in
    // arbitrary timestamps (backwards jumps and wraps) as noise. The caller
    // drops valid afterwards.
    task automatic random_run(input int count, input int unsigned max_step, input bit wild);
        for (int i = 0; i < count; i++)
        begin
            if (wild && $urandom_range(99) < 30)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, max_step);
            send_reading(random_reading(clock_ms));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: last times start at zero, so nothing fires until
    // now_ms reaches the cooldown; then every kind fires at once.
    task automatic test_holdoff_after_reset();
        send_reading(make_reading(32'd0,      1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                  10'd0, 10'd0));
        send_reading(make_reading(32'd299999, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                  10'd0, 10'd0));
        send_reading(make_reading(32'd300000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                  10'd0, 10'd0));
    endtask

    // Uncalibrated: nothing fires, but the window is still reported, last
    // millisecond inside it and then exactly at its edge.
    task automatic test_uncalibrated_hold();
        send_reading(make_reading(32'd359999, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                  10'd0, 10'd0));
        send_reading(make_reading(32'd360000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                  10'd1000, 10'd1000));
    endtask

    // Extreme registers and fields: zero cooldown, widest window, thresholds
    // at the field maximum, runs of zero acting as one, timestamp wrap.
    task automatic test_field_extremes();
        write_config(32'd0, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 4'd0);
        send_reading(make_reading(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                  10'd1000, 10'd1000));
        send_reading(make_reading(32'd0,         1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                  10'd0,    10'd0));
        send_reading(make_reading(32'd1,         1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                  10'd1000, 10'd1000));
        // Widest cooldown, zero window, zero thresholds, longest run
        write_config(32'hFFFF_FFFF, 32'd0, 10'd0, 10'd0, 4'd15);
        send_reading(make_reading(32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                  10'd0, 10'd0));
    endtask

    // Hold off the SpO2 alert with a half-range cooldown while the run
    // saturates, then let it fire once the cooldown has passed.
    task automatic test_run_saturation();
        logic [TIME_W-1:0] base;
        write_config(32'h8000_0000, 32'd60000, 10'd900, 10'd150, 4'd15);
        base = last_fire[KIND_LOW_SPO2];
        for (int i = 1; i <= 16; i++)
            send_reading(make_reading(base + TIME_W'(i), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                      1'b0, 10'd0, 10'd500));
        send_reading(make_reading(base + 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                  1'b0, 10'd0, 10'd500));
    endtask

    // Short cooldowns against a clock that wraps partway through
    task automatic test_random_steady();
        write_config(32'd5000, 32'd3000, 10'd900, 10'd150, 4'd3);
        clock_ms = 32'hFFFF_0000;
        random_run(400, 2000, 1'b0);
    endtask

    // Cooldown zero with neither side idling: back-to-back transfers
    task automatic test_random_no_idle();
        write_config(32'd0, $urandom_range(1, 400), 10'd950, 10'd300, 4'd1);
        calm = 1'b1;
        random_run(400, 100, 1'b0);
        calm = 1'b0;
    endtask

    // Widest cooldown and closed window under arbitrary timestamps
    task automatic test_random_blocked();
        write_config(32'hFFFF_FFFF, 32'd0, 10'd0, 10'd0, 4'd15);
        random_run(150, 1000, 1'b1);
    endtask

    // Random register settings, one round with arbitrary cooldown and time noise
    task automatic test_random_configs();
        logic [TIME_W-1:0] cd;
        for (int round = 0; round < 3; round++)
        begin
            cd = (round == 1) ? $urandom() : $urandom_range(0, 20000);
            write_config(cd, $urandom_range(0, 20000), TENTHS_W'($urandom_range(0, 1023)),
                         TENTHS_W'($urandom_range(0, 1023)), RUN_W'($urandom_range(0, 15)));
            random_run(350, (round == 1) ? 20000 : cd / 2 + 50, round == 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and output stall
    // ------------------------------------------------------------------

    function automatic void check_bit(input string name, input logic want, got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endfunction

    // Compare each output transfer against the oldest prediction, and
    // stall the output at random unless the run is in a calm phase.
    always @(posedge clk)
    begin
        alerts_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alerts_q.size() == 0)
            begin
                $error("alert result with no reading waiting for it");
                errors++;
            end
            else
            begin
                want = alerts_q.pop_front();
                check_bit("stress_fired",      want.stress,  stress_fired);
                check_bit("geofence_fired",    want.geo,     geofence_fired);
                check_bit("low_spo2_fired",    want.spo2,    low_spo2_fired);
                check_bit("sensor_fail_fired", want.fail,    sensor_fail_fired);
                check_bit("low_battery_fired", want.batt,    low_battery_fired);
                check_bit("vibrate_request",   want.vibrate, vibrate_request);
                check_bit("alert_active",      want.active,  alert_active);
            end
        end
        out_stall <= !calm && ($urandom_range(99) < 25);
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        holdoff_reset();
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_COOLDOWN;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        now_ms           <= '0;
        calibrated       <= 1'b0;
        stress_state     <= 1'b0;
        gps_fixed        <= 1'b0;
        outside_fence    <= 1'b0;
        spo2_error       <= 1'b0;
        any_sensor_error <= 1'b0;
        spo2_tenths      <= '0;
        battery_tenths   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_holdoff_after_reset();
        test_uncalibrated_hold();
        test_field_extremes();
        test_run_saturation();
        test_random_steady();
        test_random_no_idle();
        test_random_blocked();
        test_random_configs();

        in_valid <= 1'b0;
        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/sahe_pkg.sv
design/sahe_ram.sv
design/sahe_eval.sv
design/sahe_out_queue.sv
design/sensor_alert_holdoff_engine.sv
tb/testbench.sv
